FILE: hw/rtl/pbsm_pkg.sv
package pbsm_pkg;

   // Field widths of the request and result transfers.
   localparam int PAGE_W       = 31;
   localparam int KIND_W       = 2;
   localparam int CHOICE_W     = 6;
   localparam int SLOT_FIELD_W = 6;
   localparam int STATUS_W     = 2;

   // Default number of buffer slots.
   localparam int SLOT_COUNT_DEF = 64;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 31;

   typedef enum logic [KIND_W-1:0] {
      KIND_NEW       = 2'd0,
      KIND_GET       = 2'd1,
      KIND_FLUSH     = 2'd2,
      KIND_FLUSH_ALL = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NOT_RESIDENT = 2'd1,
      STATUS_NO_DISK      = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HAS_DISK       = 1'b0,
      CSR_FIRST_NEW_PAGE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_PLACE,
      ST_VICTIM,
      ST_FA_READ,
      ST_FA_DATA,
      ST_EMIT
   } seq_state_type;

   // Configuration seen by the sequencer.
   typedef struct packed {
      logic              has_disk;
      logic [PAGE_W-1:0] first_new_page;
   } cfg_type;

   // One result item.
   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [PAGE_W-1:0]       result_page;
      logic                    load_from_disk;
      logic                    write_back;
      logic [PAGE_W-1:0]       write_page_id;
      logic                    last;
   } rsp_item_type;

endpackage

FILE: hw/rtl/pbsm_slot_ram.sv
module pbsm_slot_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 31
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pbsm_seq.sv
module pbsm_seq #(
   parameter int SLOT_COUNT = pbsm_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_W     = $clog2(SLOT_COUNT),
   parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pbsm_pkg::cfg_type              cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pbsm_pkg::kind_type             req_kind,
   input  logic [pbsm_pkg::PAGE_W-1:0]    req_page,
   input  logic [pbsm_pkg::CHOICE_W-1:0]  req_choice,
   output logic                           res_valid,
   input  logic                           res_ready,
   output pbsm_pkg::rsp_item_type         res,
   output logic                           ram_we,
   output logic [SLOT_W-1:0]              ram_waddr,
   output logic [pbsm_pkg::PAGE_W-1:0]    ram_wdata,
   output logic [SLOT_W-1:0]              ram_raddr,
   input  logic [pbsm_pkg::PAGE_W-1:0]    ram_rdata
);

   import pbsm_pkg::*;

   localparam int EXT_W = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
   localparam int REM_W = SLOT_W + CHOICE_W + 1;

   seq_state_type        state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [SLOT_W-1:0]    choice_ff, choice_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]     filled_ff, filled_in;
   logic [PAGE_W-1:0]    new_count_ff, new_count_in;
   rsp_item_type         res_ff, res_in;

   logic                 full;
   logic                 hit;
   logic [SLOT_W-1:0]    choice_mod;
   logic [REM_W-1:0]     rem;

   // Low bits of a slot index as carried in the result.
   function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
      logic [EXT_W-1:0] e;
      e = EXT_W'(s);
      return e[SLOT_FIELD_W-1:0];
   endfunction

   // Victim choice modulo the slot count by restoring compare and subtract.
   always_comb begin
      rem = REM_W'(req_choice);
      for (int k = CHOICE_W - 1; k >= 0; k--) begin
         if (rem >= (REM_W'(SLOT_COUNT) << k)) begin
            rem = rem - (REM_W'(SLOT_COUNT) << k);
         end
      end
      choice_mod = rem[SLOT_W-1:0];
   end

   assign full = (filled_ff == CNT_W'(SLOT_COUNT));

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         new_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         new_count_ff <= new_count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      page_ff     <= page_in;
      choice_ff   <= choice_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
   end

   // Next state, table access and result building.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      page_in      = page_ff;
      choice_in    = choice_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      filled_in    = filled_ff;
      new_count_in = new_count_ff;
      res_in       = res_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      hit          = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = choice_ff;
      ram_wdata    = page_ff;
      ram_raddr    = idx_ff[SLOT_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_kind;
               page_in   = req_page;
               choice_in = choice_mod;
               idx_in    = '0;
               pend_in   = 1'b0;
               case (req_kind)
                  KIND_NEW: begin
                     page_in      = cfg.first_new_page + new_count_ff;
                     new_count_in = new_count_ff + PAGE_W'(1);
                     state_in     = ST_PLACE;
                  end
                  KIND_GET, KIND_FLUSH: begin
                     state_in = ST_LOOK;
                  end
                  KIND_FLUSH_ALL: begin
                     state_in = ST_FA_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Pipelined scan: issue one read a cycle, compare the one before.
         ST_LOOK: begin
            hit = pend_ff && (ram_rdata == page_ff);
            if (hit) begin
               res_in.status         = STATUS_OK;
               res_in.slot           = slot_field(pend_idx_ff);
               res_in.result_page    = page_ff;
               res_in.load_from_disk = 1'b0;
               res_in.write_back     = (kind_ff == KIND_FLUSH) && cfg.has_disk;
               res_in.write_page_id  = (kind_ff == KIND_FLUSH) ? page_ff : '0;
               res_in.last           = 1'b1;
               state_in              = ST_EMIT;
            end else if (idx_ff < filled_ff) begin
               ram_raddr   = idx_ff[SLOT_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[SLOT_W-1:0];
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if ((kind_ff == KIND_GET) && cfg.has_disk) begin
               state_in = ST_PLACE;
            end else begin
               res_in.status         = (kind_ff == KIND_GET) ? STATUS_NO_DISK
                                                             : STATUS_NOT_RESIDENT;
               res_in.slot           = '0;
               res_in.result_page    = page_ff;
               res_in.load_from_disk = 1'b0;
               res_in.write_back     = 1'b0;
               res_in.write_page_id  = '0;
               res_in.last           = 1'b1;
               state_in              = ST_EMIT;
            end
         end

         // Take the next free slot, or read the victim when all are full.
         ST_PLACE: begin
            if (!full) begin
               ram_we                = 1'b1;
               ram_waddr             = filled_ff[SLOT_W-1:0];
               filled_in             = filled_ff + CNT_W'(1);
               res_in.status         = STATUS_OK;
               res_in.slot           = slot_field(filled_ff[SLOT_W-1:0]);
               res_in.result_page    = page_ff;
               res_in.load_from_disk = (kind_ff == KIND_GET);
               res_in.write_back     = 1'b0;
               res_in.write_page_id  = '0;
               res_in.last           = 1'b1;
               state_in              = ST_EMIT;
            end else begin
               ram_raddr = choice_ff;
               state_in  = ST_VICTIM;
            end
         end

         // The victim's page is on the read port; overwrite its slot.
         ST_VICTIM: begin
            ram_we                = 1'b1;
            ram_waddr             = choice_ff;
            res_in.status         = STATUS_OK;
            res_in.slot           = slot_field(choice_ff);
            res_in.result_page    = page_ff;
            res_in.load_from_disk = (kind_ff == KIND_GET);
            res_in.write_back     = cfg.has_disk;
            res_in.write_page_id  = ram_rdata;
            res_in.last           = 1'b1;
            state_in              = ST_EMIT;
         end

         ST_FA_READ: begin
            if (filled_ff == '0) begin
               res_in.status         = STATUS_NOT_RESIDENT;
               res_in.slot           = '0;
               res_in.result_page    = '0;
               res_in.load_from_disk = 1'b0;
               res_in.write_back     = 1'b0;
               res_in.write_page_id  = '0;
               res_in.last           = 1'b1;
               state_in              = ST_EMIT;
            end else begin
               ram_raddr = idx_ff[SLOT_W-1:0];
               state_in  = ST_FA_DATA;
            end
         end

         ST_FA_DATA: begin
            res_in.status         = STATUS_OK;
            res_in.slot           = slot_field(idx_ff[SLOT_W-1:0]);
            res_in.result_page    = ram_rdata;
            res_in.load_from_disk = 1'b0;
            res_in.write_back     = cfg.has_disk;
            res_in.write_page_id  = ram_rdata;
            res_in.last           = ((idx_ff + CNT_W'(1)) == filled_ff);
            state_in              = ST_EMIT;
         end

         // Hand the result to the output register; flush-all loops back.
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               if ((kind_ff == KIND_FLUSH_ALL) && !res_ff.last) begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_FA_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   // The fill count never passes the slot count.
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(SLOT_COUNT))
      else $error("fill count above slot count");

   // The fill count only grows.
   a_filled_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> filled_ff >= $past(filled_ff))
      else $error("fill count decreased");

   // While slots are free, writes go to the next free slot.
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      ram_we && !full |-> ram_waddr == filled_ff[SLOT_W-1:0])
      else $error("write outside the fill order");

   // A hit always names an occupied slot.
   a_hit_occupied: assert property (@(posedge clock) disable iff (reset)
      hit |-> CNT_W'(pend_idx_ff) < filled_ff)
      else $error("hit on an unoccupied slot");

endmodule

FILE: hw/rtl/page_buffer_slot_manager.sv
// Page buffer slot manager: maps page ids onto SLOT_COUNT buffer slots.
// Requests arrive on the req_ stream (kind in req_tuser, page id and victim
// choice in req_tdata); results leave on the rsp_ stream with status in
// rsp_tuser and rsp_tlast on the final result of each request. Flush-all
// gives one result per occupied slot in ascending order, else one not-resident.
// The csr_ port writes has_disk (index 0) and first_new_page (index 1) and is
// always ready; the user writes it only while no request is in flight, as the
// block does not enforce it. One request is handled at a time; req_tready is
// high only while idle. A new page passes through the place and emit states
// before its result enters the output register; a victim read adds a state.
// Get and flush scan the slot table through its single read port, one entry
// per cycle. A get that misses with a disk goes on to a placement, and to a
// victim read when the table is full. Flush-all passes through the read, data
// and emit states per occupied slot: the registered table read, then hand-off.
// The next request is accepted in the cycle after the last result of the
// previous one enters the output register.
// The result register lets the next request be accepted while a result waits;
// a stalled receiver only holds the sequencer once the next result is ready.
// Reset empties the table (fill count zero), clears the new-page counter and
// both configuration registers; no clearing pass is needed.
module page_buffer_slot_manager #(
   parameter int SLOT_COUNT = pbsm_pkg::SLOT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata: page_id [30:0], victim_choice [36:31], zero [39:37].
   input  logic [pbsm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: kind [1:0].
   input  logic [pbsm_pkg::KIND_W-1:0]         req_tuser,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: slot [5:0], result_page [36:6], load_from_disk [37],
   // write_back [38], write_page_id [69:39], zero [71:70].
   output logic [pbsm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: status [1:0].
   output logic [pbsm_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import pbsm_pkg::*;

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   logic                 has_disk_ff;
   logic [PAGE_W-1:0]    first_new_page_ff;
   cfg_type              cfg;

   logic                 res_valid;
   logic                 res_ready;
   rsp_item_type         res;
   logic                 rsp_tvalid_ff;
   rsp_item_type         rsp_item_ff;

   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_waddr;
   logic [PAGE_W-1:0]    ram_wdata;
   logic [SLOT_W-1:0]    ram_raddr;
   logic [PAGE_W-1:0]    ram_rdata;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_disk_ff       <= 1'b0;
         first_new_page_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index_type'(csr_index) == CSR_HAS_DISK) begin
            has_disk_ff <= csr_wdata[0];
         end else if (csr_index_type'(csr_index) == CSR_FIRST_NEW_PAGE) begin
            first_new_page_ff <= csr_wdata[PAGE_W-1:0];
         end
      end
   end

   assign cfg = {has_disk_ff, first_new_page_ff};

   pbsm_seq #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_W     (SLOT_W),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (kind_type'(req_tuser)),
      .req_page   (req_tdata[PAGE_W-1:0]),
      .req_choice (req_tdata[PAGE_W+CHOICE_W-1:PAGE_W]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   pbsm_slot_ram #(
      .DEPTH  (SLOT_COUNT),
      .ADDR_W (SLOT_W),
      .DATA_W (PAGE_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Output register: loads when empty or when its transfer completes.
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tdata  = {2'b00,
                        rsp_item_ff.write_page_id,
                        rsp_item_ff.write_back,
                        rsp_item_ff.load_from_disk,
                        rsp_item_ff.result_page,
                        rsp_item_ff.slot};

endmodule

FILE: bench/pbsm_checker.sv
module pbsm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [pbsm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [pbsm_pkg::KIND_W-1:0]         req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [pbsm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic [pbsm_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                                rsp_tlast,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pbsm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbsm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  open_results
);

   timeunit 1ns;
   timeprecision 1ps;

   import pbsm_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEF;

   // Shadow copy of the slot manager state and its configuration.
   logic [PAGE_W-1:0] page_of_slot [SLOTS];
   int                slots_used;
   logic [PAGE_W-1:0] pages_created;
   logic              cfg_disk;
   logic [PAGE_W-1:0] cfg_first_page;

   // Results owed by the block, oldest first.
   rsp_item_type      awaited_results [$];

   initial begin
      fail_count   = 0;
      open_results = 0;
   end

   // One printed line and one count per mismatch.
   task automatic flag_mismatch(string what, longint unsigned seen, longint unsigned wanted);
      fail_count++;
      $display("ERROR at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, seen, wanted);
   endtask

   function automatic void owe(status_type st, logic [SLOT_FIELD_W-1:0] s,
                               logic [PAGE_W-1:0] pg, logic load, logic wb,
                               logic [PAGE_W-1:0] wpg, logic fin);
      rsp_item_type item;
      item.status         = st;
      item.slot           = s;
      item.result_page    = pg;
      item.load_from_disk = load;
      item.write_back     = wb;
      item.write_page_id  = wpg;
      item.last           = fin;
      awaited_results.push_back(item);
   endfunction

   // Lowest occupied slot that holds the page, or -1 when it is not resident.
   function automatic int lowest_slot_of(logic [PAGE_W-1:0] page);
      for (int i = 0; i < slots_used; i++) begin
         if (page_of_slot[i] == page) return i;
      end
      return -1;
   endfunction

   // Free slots are used in order; once all are full the chosen victim is reused.
   function automatic void claim_slot(input logic [PAGE_W-1:0] page,
                                      input logic [CHOICE_W-1:0] choice,
                                      output logic [SLOT_FIELD_W-1:0] s,
                                      output logic evicted,
                                      output logic [PAGE_W-1:0] victim);
      if (slots_used < SLOTS) begin
         s       = SLOT_FIELD_W'(slots_used);
         evicted = 1'b0;
         victim  = '0;
         slots_used++;
      end else begin
         s       = SLOT_FIELD_W'(choice % SLOTS);
         evicted = 1'b1;
         victim  = page_of_slot[s];
      end
      page_of_slot[s] = page;
   endfunction

   // Work out every result one accepted request causes.
   function automatic void apply_request(kind_type kind, logic [PAGE_W-1:0] page,
                                         logic [CHOICE_W-1:0] choice);
      int                      hit;
      logic [SLOT_FIELD_W-1:0] s;
      logic                    evicted;
      logic [PAGE_W-1:0]       victim;
      logic [PAGE_W-1:0]       fresh;
      case (kind)
         KIND_NEW: begin
            fresh         = cfg_first_page + pages_created;
            pages_created = pages_created + 1'b1;
            claim_slot(fresh, choice, s, evicted, victim);
            owe(STATUS_OK, s, fresh, 1'b0, evicted & cfg_disk, evicted ? victim : '0, 1'b1);
         end
         KIND_GET: begin
            hit = lowest_slot_of(page);
            if (hit >= 0) begin
               owe(STATUS_OK, SLOT_FIELD_W'(hit), page, 1'b0, 1'b0, '0, 1'b1);
            end else if (!cfg_disk) begin
               owe(STATUS_NO_DISK, '0, page, 1'b0, 1'b0, '0, 1'b1);
            end else begin
               claim_slot(page, choice, s, evicted, victim);
               owe(STATUS_OK, s, page, 1'b1, evicted, evicted ? victim : '0, 1'b1);
            end
         end
         KIND_FLUSH: begin
            hit = lowest_slot_of(page);
            if (hit >= 0) begin
               owe(STATUS_OK, SLOT_FIELD_W'(hit), page, 1'b0, cfg_disk, page, 1'b1);
            end else begin
               owe(STATUS_NOT_RESIDENT, '0, page, 1'b0, 1'b0, '0, 1'b1);
            end
         end
         default: begin
            // Flush-all: one result per occupied slot, or a lone not-resident result.
            if (slots_used == 0) begin
               owe(STATUS_NOT_RESIDENT, '0, '0, 1'b0, 1'b0, '0, 1'b1);
            end else begin
               for (int i = 0; i < slots_used; i++) begin
                  owe(STATUS_OK, SLOT_FIELD_W'(i), page_of_slot[i], 1'b0, cfg_disk,
                      page_of_slot[i], i == slots_used - 1);
               end
            end
         end
      endcase
   endfunction

   // Compare one result transfer against the oldest owed result.
   task automatic check_result();
      rsp_item_type want;
      if (awaited_results.size() == 0) begin
         flag_mismatch("result transfer with none awaited", rsp_tdata[63:0], 0);
      end else begin
         want = awaited_results[0];
         awaited_results.delete(0);
         if (rsp_tuser !== want.status)
            flag_mismatch("status", rsp_tuser, want.status);
         if (rsp_tdata[5:0] !== want.slot)
            flag_mismatch("slot", rsp_tdata[5:0], want.slot);
         if (rsp_tdata[36:6] !== want.result_page)
            flag_mismatch("result_page", rsp_tdata[36:6], want.result_page);
         if (rsp_tdata[37] !== want.load_from_disk)
            flag_mismatch("load_from_disk", rsp_tdata[37], want.load_from_disk);
         if (rsp_tdata[38] !== want.write_back)
            flag_mismatch("write_back", rsp_tdata[38], want.write_back);
         if (rsp_tdata[69:39] !== want.write_page_id)
            flag_mismatch("write_page_id", rsp_tdata[69:39], want.write_page_id);
         if (rsp_tlast !== want.last)
            flag_mismatch("last", rsp_tlast, want.last);
      end
   endtask

   // Sample every channel at the rising edge; results go first, then
   // register writes, then new requests.
   always @(posedge clock) begin
      if (reset) begin
         slots_used     = 0;
         pages_created  = '0;
         cfg_disk       = 1'b0;
         cfg_first_page = '0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_HAS_DISK:       cfg_disk = csr_wdata[0];
               CSR_FIRST_NEW_PAGE: cfg_first_page = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            apply_request(kind_type'(req_tuser), req_tdata[30:0], req_tdata[36:31]);
      end
      open_results = awaited_results.size();
   end

endmodule

FILE: bench/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import pbsm_pkg::*;

   localparam int PHASE_ITEMS = 100;
   localparam int LONG_HOLD   = 400;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic [KIND_W-1:0]       req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   int fail_count;
   int open_results;

   // Stimulus bookkeeping: recent page ids, so that lookups often hit.
   logic [PAGE_W-1:0] known_pages [$];
   logic [PAGE_W-1:0] fresh_base    = '0;
   logic [PAGE_W-1:0] pages_issued  = '0;
   int                burst_left    = 0;
   bit                long_stall_due = 1'b0;

   always #2 clock = ~clock;

   page_buffer_slot_manager i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pbsm_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .open_results (open_results)
   );

   // Offer one request until it transfers, then pace the sender in bursts.
   // Called at a falling edge; returns at a falling edge.
   task automatic issue_request(kind_type kind, logic [PAGE_W-1:0] page,
                                logic [CHOICE_W-1:0] choice);
      int gap;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, choice, page};
      req_tvalid <= 1'b1;
      if (kind == KIND_NEW) begin
         known_pages.push_back(fresh_base + pages_issued);
         pages_issued = pages_issued + 1'b1;
      end else if (kind == KIND_GET) begin
         known_pages.push_back(page);
      end
      if (known_pages.size() > 96) known_pages.delete(0);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Write both registers back to back; the block must be idle.
   task automatic apply_setting(logic disk, logic [PAGE_W-1:0] first);
      csr_valid <= 1'b1;
      csr_index <= CSR_HAS_DISK;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, disk};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_FIRST_NEW_PAGE;
      csr_wdata <= first;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid  <= 1'b0;
      fresh_base = first;
   endtask

   // Stop offering and wait until every owed result has transferred.
   task automatic settle(int tail);
      req_tvalid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   function automatic logic [PAGE_W-1:0] pick_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60 && known_pages.size() > 0)
         return known_pages[$urandom_range(0, known_pages.size() - 1)];
      if (r < 85) return PAGE_W'($urandom_range(0, 255));
      return PAGE_W'($urandom);
   endfunction

   // Mostly lookups and new pages with live ids; flush-all now and then.
   task automatic random_request();
      int       r;
      kind_type kind;
      r = $urandom_range(0, 99);
      if (r < 30)      kind = KIND_NEW;
      else if (r < 65) kind = KIND_GET;
      else if (r < 91) kind = KIND_FLUSH;
      else             kind = KIND_FLUSH_ALL;
      issue_request(kind, pick_page(), CHOICE_W'($urandom_range(0, 63)));
   endtask

   // Result side: stall on a pattern of its own, with one long hold-off.
   initial begin : rsp_side
      logic [15:0] ready_pattern;
      int          span;
      @(negedge clock);
      forever begin
         span = $urandom_range(16, 160);
         case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom);
            2:       ready_pattern = 16'h1111;
            default: ready_pattern = 16'($urandom) | 16'h8001;
         endcase
         if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
         for (int c = 0; c < span; c++) begin
            if (long_stall_due) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
               long_stall_due = 1'b0;
            end
            rsp_tready <= ready_pattern[c % 16];
            @(negedge clock);
         end
      end
   end

   // Request side: directed part, then random phases under changing settings.
   initial begin : req_side
      logic              disk;
      logic [PAGE_W-1:0] first;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table without a disk; new page ids wrap past the top.
      apply_setting(1'b0, 31'h7FFF_FFFE);
      issue_request(KIND_FLUSH_ALL, 31'h0, 6'd0);
      issue_request(KIND_GET, 31'h7FFF_FFFF, 6'd63);
      issue_request(KIND_FLUSH, 31'h0, 6'd0);
      issue_request(KIND_NEW, 31'h0, 6'd63);
      issue_request(KIND_NEW, 31'h7FFF_FFFF, 6'd0);
      issue_request(KIND_NEW, 31'h2AAA_AAAA, 6'd42);
      issue_request(KIND_GET, 31'h7FFF_FFFF, 6'd21);
      issue_request(KIND_GET, 31'h2AAA_AAAA, 6'd0);
      issue_request(KIND_FLUSH, 31'h0, 6'd63);
      issue_request(KIND_FLUSH_ALL, 31'h7FFF_FFFF, 6'd63);

      // With a disk; the next new page reissues id zero, so it lives twice.
      settle(8);
      apply_setting(1'b1, 31'h0 - pages_issued);
      issue_request(KIND_NEW, 31'h5555_5555, 6'd1);
      issue_request(KIND_GET, 31'h0, 6'd0);
      issue_request(KIND_FLUSH, 31'h0, 6'd0);
      issue_request(KIND_GET, 31'h5555_5555, 6'd63);
      issue_request(KIND_GET, 31'h5555_5555, 6'd0);
      issue_request(KIND_FLUSH, 31'h0001_2345, 6'd5);
      issue_request(KIND_FLUSH_ALL, 31'h0, 6'd0);

      // Random phases; the table fills early and evictions dominate later.
      for (int p = 0; p < 5; p++) begin
         settle(8);
         case (p)
            0:       begin disk = 1'b1; first = 31'd100; end
            1:       begin disk = 1'b0; first = 31'h7FFF_FFFF; end
            2:       begin disk = 1'b1; first = PAGE_W'($urandom); end
            3:       begin disk = 1'b0; first = 31'h0; end
            default: begin disk = 1'b1; first = 31'd100 - pages_issued + 31'd150; end
         endcase
         apply_setting(disk, first);
         if (p == 1) long_stall_due = 1'b1;
         repeat (PHASE_ITEMS) random_request();
      end

      settle(200);
      if (fail_count == 0) begin
         $display("page_buffer_slot_manager: match");
      end else begin
         $display("page_buffer_slot_manager: mismatch");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #8_000_000;
      $display("page_buffer_slot_manager: mismatch");
      $finish;
   end

endmodule
